>>> design/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define PTCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds across reset
`define PTCC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ptcc_pkg.sv
// types and constants shared by the packet time continuity checker
package ptcc_pkg;

  localparam int TS_W    = 54;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN = 1'b1;

  // input word: one packet header
  typedef struct packed {
    logic [7:0]  year_offset;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] micro_count;
    logic [15:0] packet_length;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [TS_W-1:0] timestamp_us;
    logic [1:0]      status;
  } out_word_t;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TIME = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  // micro-operations
  typedef enum logic [2:0] {
    OP_ACC,
    OP_BR_TIME,
    OP_BR_LEN,
    OP_FIN_OK,
    OP_FIN_TIME,
    OP_FIN_LEN
  } uop_t;

  // multiplier constant select
  typedef enum logic [2:0] {
    K_ZERO,
    K_ONE,
    K_365,
    K_24,
    K_60,
    K_1E6
  } kmul_t;

  // addend select
  typedef enum logic [3:0] {
    A_NONE,
    A_YEAR,
    A_Q4,
    A_Q100,
    A_Q400,
    A_DOY,
    A_DAY,
    A_BIAS,
    A_HOUR,
    A_MIN,
    A_SEC,
    A_MICRO
  } addsel_t;

  typedef logic [3:0] upc_t;

  // one control word of the program
  typedef struct packed {
    uop_t    op;
    kmul_t   kmul;
    addsel_t asel;
    logic    sub;
    upc_t    target;
  } uword_t;

  // sequencer to datapath control
  typedef struct packed {
    logic   step_en;
    uword_t uw;
  } ctrl_t;

  // datapath to sequencer condition flags
  typedef struct packed {
    logic time_bad;
    logic len_bad;
  } dp_flags_t;

endpackage

>>> design/ptcc_seq.sv
// microcode sequencer: program rom, step counter and conditional jumps
module ptcc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_free,
  input  ptcc_pkg::dp_flags_t flags,
  output ptcc_pkg::ctrl_t    ctrl,
  output logic               busy
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t           state_r;
  ptcc_pkg::upc_t   pc_r;
  ptcc_pkg::upc_t   pc_nxt;
  ptcc_pkg::uword_t uw;
  logic             is_fin;
  logic             step_en;

  // program: calendar to days, horner to microseconds, then the checks
  function automatic ptcc_pkg::uword_t urom(input ptcc_pkg::upc_t pc);
    ptcc_pkg::uword_t w;
    w.op     = ptcc_pkg::OP_ACC;
    w.kmul   = ptcc_pkg::K_ONE;
    w.asel   = ptcc_pkg::A_NONE;
    w.sub    = 1'b0;
    w.target = '0;
    case (pc)
      4'd0:  begin w.kmul = ptcc_pkg::K_ZERO; w.asel = ptcc_pkg::A_YEAR; end
      4'd1:  begin w.kmul = ptcc_pkg::K_365;  w.asel = ptcc_pkg::A_Q4;   end
      4'd2:  begin w.asel = ptcc_pkg::A_Q100; w.sub = 1'b1;              end
      4'd3:  begin w.asel = ptcc_pkg::A_Q400;                            end
      4'd4:  begin w.asel = ptcc_pkg::A_DOY;                             end
      4'd5:  begin w.asel = ptcc_pkg::A_DAY;                             end
      4'd6:  begin w.asel = ptcc_pkg::A_BIAS; w.sub = 1'b1;              end
      4'd7:  begin w.kmul = ptcc_pkg::K_24;   w.asel = ptcc_pkg::A_HOUR;  end
      4'd8:  begin w.kmul = ptcc_pkg::K_60;   w.asel = ptcc_pkg::A_MIN;   end
      4'd9:  begin w.kmul = ptcc_pkg::K_60;   w.asel = ptcc_pkg::A_SEC;   end
      4'd10: begin w.kmul = ptcc_pkg::K_1E6;  w.asel = ptcc_pkg::A_MICRO; end
      4'd11: begin w.op = ptcc_pkg::OP_BR_TIME; w.target = 4'd14;        end
      4'd12: begin w.op = ptcc_pkg::OP_BR_LEN;  w.target = 4'd15;        end
      4'd13: begin w.op = ptcc_pkg::OP_FIN_OK;                           end
      4'd14: begin w.op = ptcc_pkg::OP_FIN_TIME;                         end
      4'd15: begin w.op = ptcc_pkg::OP_FIN_LEN;                          end
      default: begin w.op = ptcc_pkg::OP_FIN_OK;                         end
    endcase
    return w;
  endfunction

  // decode the current control word
  always_comb begin
    uw = urom(pc_r);
    case (uw.op) inside
      ptcc_pkg::OP_FIN_OK, ptcc_pkg::OP_FIN_TIME, ptcc_pkg::OP_FIN_LEN: is_fin = 1'b1;
      default: is_fin = 1'b0;
    endcase
    step_en = (state_r == S_RUN) && (!is_fin || out_free);
  end

  // next step address
  always_comb begin
    case (uw.op)
      ptcc_pkg::OP_BR_TIME: pc_nxt = flags.time_bad ? uw.target : ptcc_pkg::upc_t'(pc_r + 4'd1);
      ptcc_pkg::OP_BR_LEN:  pc_nxt = flags.len_bad  ? uw.target : ptcc_pkg::upc_t'(pc_r + 4'd1);
      default:              pc_nxt = ptcc_pkg::upc_t'(pc_r + 4'd1);
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            pc_r    <= '0;
          end
        end
        S_RUN: begin
          if (step_en) begin
            if (is_fin) begin
              state_r <= S_IDLE;
            end else begin
              pc_r <= pc_nxt;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ctrl.step_en = step_en;
  assign ctrl.uw      = uw;
  assign busy         = (state_r == S_RUN);

endmodule

>>> design/ptcc_dp.sv
// datapath: header register, multiply-accumulate, stored time and settings
module ptcc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  ptcc_pkg::in_word_t              in_data,
  input  logic                            cfg_wr_en,
  input  logic [ptcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptcc_pkg::CFG_W-1:0]      cfg_data,
  input  ptcc_pkg::ctrl_t                 ctrl,
  output ptcc_pkg::dp_flags_t             flags,
  output logic [ptcc_pkg::TS_W-1:0]       ts
);

  localparam int MUL_W = 34;
  localparam int K_W   = 20;
  localparam logic [31:0] DAYS_BIAS = 32'd135081;

  // year adjust code: 0 one back, 1 none, 2 one on
  typedef struct packed {
    logic [1:0] yadj;
    logic [8:0] doy;
  } month_t;

  ptcc_pkg::in_word_t        item_r;
  logic [ptcc_pkg::TS_W-1:0] acc_r;
  logic [ptcc_pkg::TS_W-1:0] acc_nxt;
  logic [ptcc_pkg::TS_W-1:0] last_time_r;
  logic                      last_valid_r;
  logic [31:0]               inc_r;
  logic [15:0]               exp_len_r;

  month_t                    mi;
  logic [9:0]                yq;
  logic [20:0]               m100;
  logic [3:0]                q100;
  logic                      q400;
  logic [31:0]               addend;
  logic [K_W-1:0]            kval;
  logic [ptcc_pkg::TS_W-1:0] prod;
  logic [ptcc_pkg::TS_W:0]   expect_ts;

  // month to year shift and day of march-based year
  function automatic month_t month_info(input logic [3:0] m);
    month_t r;
    case (m)
      4'd0:  r = '{yadj: 2'd0, doy: 9'd275};
      4'd1:  r = '{yadj: 2'd0, doy: 9'd306};
      4'd2:  r = '{yadj: 2'd0, doy: 9'd337};
      4'd3:  r = '{yadj: 2'd1, doy: 9'd0};
      4'd4:  r = '{yadj: 2'd1, doy: 9'd31};
      4'd5:  r = '{yadj: 2'd1, doy: 9'd61};
      4'd6:  r = '{yadj: 2'd1, doy: 9'd92};
      4'd7:  r = '{yadj: 2'd1, doy: 9'd122};
      4'd8:  r = '{yadj: 2'd1, doy: 9'd153};
      4'd9:  r = '{yadj: 2'd1, doy: 9'd184};
      4'd10: r = '{yadj: 2'd1, doy: 9'd214};
      4'd11: r = '{yadj: 2'd1, doy: 9'd245};
      4'd12: r = '{yadj: 2'd1, doy: 9'd275};
      4'd13: r = '{yadj: 2'd1, doy: 9'd306};
      4'd14: r = '{yadj: 2'd1, doy: 9'd337};
      default: r = '{yadj: 2'd2, doy: 9'd0};
    endcase
    return r;
  endfunction

  // year terms, counted from 1600 so the leap corrections stay small
  always_comb begin
    mi   = month_info(item_r.month);
    yq   = 10'(10'd399 + {2'b00, item_r.year_offset} + {8'b0, mi.yadj});
    m100 = {11'b0, yq} * 21'd1311;
    q100 = m100[20:17];
    q400 = (yq >= 10'd400);
  end

  // addend select
  always_comb begin
    case (ctrl.uw.asel)
      ptcc_pkg::A_YEAR:  addend = {22'b0, yq};
      ptcc_pkg::A_Q4:    addend = {24'b0, yq[9:2]};
      ptcc_pkg::A_Q100:  addend = {28'b0, q100};
      ptcc_pkg::A_Q400:  addend = {31'b0, q400};
      ptcc_pkg::A_DOY:   addend = {23'b0, mi.doy};
      ptcc_pkg::A_DAY:   addend = {27'b0, item_r.day};
      ptcc_pkg::A_BIAS:  addend = DAYS_BIAS;
      ptcc_pkg::A_HOUR:  addend = {27'b0, item_r.hour};
      ptcc_pkg::A_MIN:   addend = {26'b0, item_r.minute};
      ptcc_pkg::A_SEC:   addend = {26'b0, item_r.second};
      ptcc_pkg::A_MICRO: addend = item_r.micro_count;
      default:           addend = '0;
    endcase
  end

  // multiplier constant select
  always_comb begin
    case (ctrl.uw.kmul)
      ptcc_pkg::K_ZERO: kval = '0;
      ptcc_pkg::K_ONE:  kval = K_W'(1);
      ptcc_pkg::K_365:  kval = K_W'(365);
      ptcc_pkg::K_24:   kval = K_W'(24);
      ptcc_pkg::K_60:   kval = K_W'(60);
      ptcc_pkg::K_1E6:  kval = K_W'(1000000);
      default:          kval = '0;
    endcase
  end

  // multiply-accumulate, day zero sits before the first of the month so day 0 works
  always_comb begin
    prod = {{(ptcc_pkg::TS_W-MUL_W){1'b0}}, acc_r[MUL_W-1:0]}
         * {{(ptcc_pkg::TS_W-K_W){1'b0}}, kval};
    if (ctrl.uw.sub) begin
      acc_nxt = prod - {{(ptcc_pkg::TS_W-32){1'b0}}, addend};
    end else begin
      acc_nxt = prod + {{(ptcc_pkg::TS_W-32){1'b0}}, addend};
    end
  end

  // condition flags for the branch steps
  always_comb begin
    expect_ts      = {1'b0, last_time_r} + {{(ptcc_pkg::TS_W-31){1'b0}}, inc_r};
    flags.time_bad = last_valid_r && ({1'b0, acc_r} != expect_ts);
    flags.len_bad  = (item_r.packet_length != exp_len_r);
  end

  // header and accumulator
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.step_en && ctrl.uw.op == ptcc_pkg::OP_ACC) begin
      acc_r <= acc_nxt;
    end
  end

  // settings and last good time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r        <= '0;
      exp_len_r    <= '0;
      last_time_r  <= '0;
      last_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          ptcc_pkg::CFG_IDX_INC: inc_r     <= cfg_data;
          ptcc_pkg::CFG_IDX_LEN: exp_len_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (ctrl.step_en && ctrl.uw.op == ptcc_pkg::OP_FIN_OK) begin
        last_time_r  <= acc_r;
        last_valid_r <= 1'b1;
      end
    end
  end

  assign ts = acc_r;

endmodule

>>> design/packet_time_continuity_checker.sv
// top level of the packet time continuity checker
//
//   channel  direction  handshake            word
//   in_      input      in_valid/in_ready    in_data (header and packet length)
//   out_     output     out_valid/out_ready  out_data (timestamp and status)
//   cfg_     input      cfg_wr_en            cfg_index, cfg_data
//
// a header takes 13 to 14 steps of the microcode sequencer after it is taken:
// eleven multiply-accumulate steps through the one 34x20 multiplier, then the checks.
// a new header is taken only once the sequencer is idle, so not before the last one is through.
// the result sits in an output register; the sequencer holds on its final step
// while that register is still full and out_ready is low.
// reset (synchronous) clears the sequencer, the settings, the stored time and out_valid.
module packet_time_continuity_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ptcc_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ptcc_pkg::out_word_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [ptcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptcc_pkg::CFG_W-1:0]      cfg_data
);

  ptcc_pkg::ctrl_t           ctrl;
  ptcc_pkg::dp_flags_t       flags;
  logic [ptcc_pkg::TS_W-1:0] ts;
  logic                      busy;
  logic                      in_acc;
  logic                      out_free;
  logic                      fin_now;
  logic [1:0]                status;
  logic                      out_valid_r;
  ptcc_pkg::out_word_t       out_data_r;

  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  ptcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  ptcc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .flags     (flags),
    .ts        (ts)
  );

  // status from the final step taken
  always_comb begin
    fin_now = 1'b0;
    status  = ptcc_pkg::ST_OK;
    case (ctrl.uw.op)
      ptcc_pkg::OP_FIN_OK:   begin fin_now = ctrl.step_en; status = ptcc_pkg::ST_OK;   end
      ptcc_pkg::OP_FIN_TIME: begin fin_now = ctrl.step_en; status = ptcc_pkg::ST_TIME; end
      ptcc_pkg::OP_FIN_LEN:  begin fin_now = ctrl.step_en; status = ptcc_pkg::ST_LEN;  end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_now) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk) begin
    if (fin_now) begin
      out_data_r.timestamp_us <= ts;
      out_data_r.status       <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/ptcc_chk.sv
// port checker for the packet time continuity checker, with its bind
`include "assert_macros.svh"

module ptcc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ptcc_pkg::out_word_t out_data
);

  // one header at a time: busy straight after taking a word
  `PTCC_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready, "ready after take")

  // a result waiting for the sink holds still
  `PTCC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out moved")

  // only the three defined status codes leave the block
  `PTCC_ASSERT(a_status_code, out_valid |-> (out_data.status == ptcc_pkg::ST_OK) || (out_data.status == ptcc_pkg::ST_TIME) || (out_data.status == ptcc_pkg::ST_LEN), "bad status code")

  // a new result coincides with the sequencer going idle
  `PTCC_ASSERT(a_idle_on_result, $rose(out_valid) |-> in_ready, "result while busy")

  // reset leaves the block empty and ready
  `PTCC_ASSERT_RST(a_reset_state, !rst_n |=> !out_valid && in_ready, "reset state wrong")

endmodule

bind packet_time_continuity_checker ptcc_chk u_ptcc_chk (.*);

>>> sim/tb_packet_time_continuity_checker.sv
// testbench for the packet time continuity checker: directed and random headers, scoreboard
module tb_packet_time_continuity_checker;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  ptcc_pkg::in_word_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ptcc_pkg::out_word_t            out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [ptcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ptcc_pkg::CFG_W-1:0]     cfg_data  = '0;

  // settings and stored time as the block should hold them
  logic [31:0]               step_us    = '0;
  logic [15:0]               need_len   = '0;
  logic [ptcc_pkg::TS_W-1:0] held_stamp = '0;
  logic                      held_valid = 1'b0;
  ptcc_pkg::in_word_t        held_hdr   = '0;

  ptcc_pkg::out_word_t pending_reports[$];
  int unsigned         mismatches = 0;

  // stall control shared by the test sequence and the result sink
  logic        idling      = 1'b1;
  int unsigned hold_reqs   = 0;
  int unsigned hold_taken  = 0;
  int unsigned stall_left  = 0;

  packet_time_continuity_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_packet_time_continuity_checker: FAIL");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned month_days(int unsigned yo, int unsigned mo);
    int unsigned yr;
    yr = 2000 + yo;
    case (mo)
      2: return ((yr % 4 == 0) && (yr % 100 != 0 || yr % 400 == 0)) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // calendar header to microseconds since 1970, read as utc, with mktime style carries
  function automatic logic [ptcc_pkg::TS_W-1:0] stamp_of(ptcc_pkg::in_word_t w);
    longint      yr, mo, mp, doy, days, secs;
    logic [63:0] us;
    yr = 2000 + longint'(w.year_offset);
    mo = longint'(w.month);
    if (mo == 0) begin
      yr = yr - 1;
      mo = 12;
    end else if (mo > 12) begin
      yr = yr + 1;
      mo = mo - 12;
    end
    // march based year so the leap day falls last
    if (mo <= 2) begin
      yr = yr - 1;
      mp = mo + 9;
    end else begin
      mp = mo - 3;
    end
    doy  = (153 * mp + 2) / 5;
    days = yr * 365 + yr / 4 - yr / 100 + yr / 400 + doy - 719468 + longint'(w.day) - 1;
    secs = days * 86400 + longint'(w.hour) * 3600 + longint'(w.minute) * 60
         + longint'(w.second);
    us = 64'(secs) * 64'd1000000 + 64'(w.micro_count);
    return us[ptcc_pkg::TS_W-1:0];
  endfunction

  // timestamp and status of one header; a clean header becomes the stored time
  function automatic ptcc_pkg::out_word_t convert_and_check(ptcc_pkg::in_word_t w);
    ptcc_pkg::out_word_t r;
    r.timestamp_us = stamp_of(w);
    if (held_valid &&
        !(r.timestamp_us >= held_stamp && r.timestamp_us - held_stamp == step_us)) begin
      r.status = ptcc_pkg::ST_TIME;
    end else if (w.packet_length != need_len) begin
      r.status = ptcc_pkg::ST_LEN;
    end else begin
      r.status   = ptcc_pkg::ST_OK;
      held_stamp = r.timestamp_us;
      held_valid = 1'b1;
      held_hdr   = w;
    end
    return r;
  endfunction

  // header one increment later; the surplus goes to hours, whole days into the date
  function automatic ptcc_pkg::in_word_t advance_header(ptcc_pkg::in_word_t h,
                                                        logic [31:0] inc);
    logic [63:0] acc;
    int unsigned hr, dy, mo, yo;
    acc           = 64'(h.micro_count) + 64'(inc);
    hr            = 32'(h.hour) + 32'(acc / 64'd3_600_000_000);
    h.micro_count = 32'(acc % 64'd3_600_000_000);
    dy = 32'(h.day);
    mo = 32'(h.month);
    yo = 32'(h.year_offset);
    while (hr >= 24) begin
      hr = hr - 24;
      dy = dy + 1;
      if (dy > month_days(yo, mo)) begin
        dy = 1;
        if (mo == 12) begin
          mo = 1;
          yo = yo + 1;
        end else begin
          mo = mo + 1;
        end
      end
    end
    h.hour        = 5'(hr);
    h.day         = 5'(dy);
    h.month       = 4'(mo);
    h.year_offset = 8'(yo);
    return h;
  endfunction

  function automatic ptcc_pkg::in_word_t make_hdr(int unsigned yo, int unsigned mo,
                                                  int unsigned dy, int unsigned hr,
                                                  int unsigned mi, int unsigned se,
                                                  logic [31:0] us, logic [15:0] len);
    ptcc_pkg::in_word_t w;
    w.year_offset   = 8'(yo);
    w.month         = 4'(mo);
    w.day           = 5'(dy);
    w.hour          = 5'(hr);
    w.minute        = 6'(mi);
    w.second        = 6'(se);
    w.micro_count   = us;
    w.packet_length = len;
    return w;
  endfunction

  function automatic void note_failure(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endfunction

  // scoreboard: results against the oldest pending word, then record new headers
  always @(posedge clk) begin : report_monitor
    ptcc_pkg::out_word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          note_failure($sformatf("unexpected result ts %0d status %0d",
                                 out_data.timestamp_us, out_data.status));
        end else begin
          want = pending_reports.pop_front();
          if (out_data.timestamp_us !== want.timestamp_us || out_data.status !== want.status)
            note_failure($sformatf("mismatch: ts exp %0d got %0d, status exp %0d got %0d",
                                   want.timestamp_us, out_data.timestamp_us,
                                   want.status, out_data.status));
        end
      end
      if (in_valid && in_ready) pending_reports.push_back(convert_and_check(in_data));
    end
  end

  // result sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin : sink_side
    int unsigned n;
    if (hold_taken != hold_reqs) begin
      hold_taken <= hold_reqs;
      stall_left <= 399;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      n = (idling && $urandom_range(0, 7) == 0) ? pick_gap() : 0;
      out_ready  <= (n == 0);
      stall_left <= (n == 0) ? 0 : n - 1;
    end
  end

  // offer one word, return at the edge that takes it with valid still high
  task automatic offer_header(ptcc_pkg::in_word_t w);
    int unsigned gap;
    gap = idling ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every result is back; one edge first so the last word is recorded
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic apply_settings(logic [31:0] inc, logic [15:0] len);
    cfg_wr_en <= 1'b1;
    cfg_index <= ptcc_pkg::CFG_IDX_INC;
    cfg_data  <= inc;
    @(posedge clk);
    cfg_index <= ptcc_pkg::CFG_IDX_LEN;
    cfg_data  <= {16'h0000, len};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_us  = inc;
    need_len = len;
  endtask

  // mostly continuing headers, some broken ones, some noise
  task automatic run_mixed_stream(int unsigned count);
    ptcc_pkg::in_word_t chain_hdr, w;
    logic [95:0]        noise;
    int unsigned        r;
    chain_hdr = held_hdr;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        chain_hdr = advance_header(chain_hdr, step_us);
        chain_hdr.packet_length = need_len;
        w = chain_hdr;
      end else if (r < 90) begin
        w = advance_header(chain_hdr, step_us);
        w.packet_length = need_len;
        case ($urandom_range(0, 3))
          0: w.micro_count ^= 32'd1 << $urandom_range(0, 31);
          1: w.packet_length ^= 16'd1 << $urandom_range(0, 15);
          2: begin
            w.micro_count ^= 32'd1 << $urandom_range(0, 31);
            w.packet_length ^= 16'd1 << $urandom_range(0, 15);
          end
          default: w = chain_hdr;
        endcase
      end else begin
        noise = {$urandom(), $urandom(), $urandom()};
        w = noise[$bits(ptcc_pkg::in_word_t)-1:0];
      end
      offer_header(w);
    end
  endtask

  // calendar extremes and out of range fields, all with a wrong length
  task automatic test_calendar_edges();
    apply_settings(32'd1_000_000, 16'd1024);
    offer_header(make_hdr(0, 1, 1, 0, 0, 0, 32'd0, 16'h0000));
    offer_header(make_hdr(255, 12, 31, 23, 59, 59, 32'hFFFF_FFFF, 16'hFFFF));
    offer_header(make_hdr(255, 15, 31, 31, 63, 63, 32'hFFFF_FFFF, 16'hFFFF));
    offer_header(make_hdr(0, 0, 0, 0, 0, 0, 32'd0, 16'h0000));
    offer_header(make_hdr(24, 13, 1, 5, 6, 7, 32'd123, 16'd1023));
    offer_header(make_hdr(24, 14, 15, 8, 9, 10, 32'd999_999, 16'd1025));
    offer_header(make_hdr(24, 3, 0, 0, 0, 0, 32'd0, 16'h5555));
    offer_header(make_hdr(23, 2, 29, 1, 2, 3, 32'd0, 16'hAAAA));
    offer_header(make_hdr(0, 2, 29, 12, 0, 0, 32'd0, 16'd0));
    offer_header(make_hdr(100, 2, 29, 12, 0, 0, 32'd0, 16'd0));
    offer_header(make_hdr(24, 4, 31, 0, 0, 0, 32'd1, 16'd0));
    offer_header(make_hdr(24, 6, 15, 31, 63, 63, 32'd0, 16'd0));
    offer_header(make_hdr(24, 1, 1, 0, 0, 0, 32'h8000_0000, 16'd1025));
  endtask

  // ok, wrong step, backwards, repeat, wrong length and both errors at once
  task automatic test_status_codes();
    ptcc_pkg::in_word_t b0, b1, b2, w;
    b0 = make_hdr(24, 6, 15, 12, 30, 45, 32'd500_000, 16'd1024);
    b1 = advance_header(b0, step_us);
    b2 = advance_header(b1, step_us);
    offer_header(b0);
    offer_header(b1);
    offer_header(b1);
    offer_header(b0);
    w = b2;
    w.micro_count = w.micro_count + 32'd1;
    offer_header(w);
    w = b2;
    w.packet_length = 16'd1023;
    offer_header(w);
    w.micro_count = w.micro_count + 32'd1;
    w.packet_length = 16'd0;
    offer_header(w);
    offer_header(b2);
  endtask

  task automatic test_mixed(logic [31:0] inc, logic [15:0] len, int unsigned count);
    wait_drained();
    apply_settings(inc, len);
    run_mixed_stream(count);
  endtask

  // sink holds off for a long stretch while words keep coming back to back
  task automatic test_output_backpressure();
    wait_drained();
    idling    <= 1'b0;
    hold_reqs <= hold_reqs + 1;
    run_mixed_stream(24);
    idling    <= 1'b1;
  endtask

  // no gaps on either side
  task automatic test_unbroken_flow();
    wait_drained();
    idling <= 1'b0;
    apply_settings(32'($urandom_range(1, 5_000_000)), 16'($urandom_range(0, 65535)));
    run_mixed_stream(200);
    idling <= 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_calendar_edges();
    test_status_codes();
    test_mixed(32'd1_000_000, 16'd1024, 220);
    test_mixed(32'd0, 16'd0, 200);
    test_mixed(32'hFFFF_FFFF, 16'hFFFF, 200);
    test_output_backpressure();
    test_unbroken_flow();
    test_mixed($urandom(), 16'($urandom_range(0, 65535)), 200);
    test_mixed(32'($urandom_range(1, 100_000)), 16'($urandom_range(0, 65535)), 250);
    test_mixed(32'($urandom_range(0, 10)), 16'd64, 250);
    wait_drained();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb_packet_time_continuity_checker: PASS");
    end else begin
      $display("tb_packet_time_continuity_checker: FAIL");
    end
    $finish;
  end

endmodule
